[rtl/efd_pkg.sv]
// Shared constants, types and arithmetic helpers for the one-bit error-diffusion dither.
package efd_pkg;

  localparam int LINE_WIDTH = 448;
  localparam int ERROR_BITS = 12;
  localparam int COL_W      = $clog2(LINE_WIDTH);
  localparam int ROW_W      = 10;
  localparam int HEIGHT_W   = 11;
  localparam int PIX_W      = 8;
  localparam int THR_W      = 8;
  localparam int SUM_W      = ERROR_BITS + 3;
  localparam int DIFF_W     = ERROR_BITS + 1;
  localparam int PROD_W     = DIFF_W + 3;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [HEIGHT_W-1:0] MAX_HEIGHT      = HEIGHT_W'(1024);
  localparam logic [THR_W-1:0]    THRESHOLD_RESET = THR_W'(127);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET    = HEIGHT_W'(240);

  // Register indexes, taken from paddr bit 2.
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_HEIGHT    = 1'b1;

  typedef logic signed [ERROR_BITS-1:0] err_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             last_col;
    logic             last_row;
  } efd_ctl_t;

  // Clamp a wide signed sum to the error range.
  function automatic err_t sat_err(input logic signed [SUM_W-1:0] v);
    err_t r;
    if (v[SUM_W-1:ERROR_BITS-1] == {(SUM_W-ERROR_BITS+1){v[SUM_W-1]}}) begin
      r = v[ERROR_BITS-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(ERROR_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(ERROR_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  // Signed division by sixteen that truncates toward zero.
  function automatic err_t div16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] b;
    logic signed [PROD_W-1:0] s;
    b = p + $signed({{(PROD_W-4){1'b0}}, {4{p[PROD_W-1]}}});
    s = b >>> 4;
    return s[ERROR_BITS-1:0];
  endfunction

endpackage

[rtl/error_diffusion_dither_1bit.sv]
// Top level of the one-bit Floyd-Steinberg error-diffusion dither.
//
// Grey pixels enter one item per clock in raster order over rows of LINE_WIDTH pixels, and
// every eighth pixel of a row (and the last pixel of a row) produces one packed byte, most
// significant bit leftmost, flagged end_of_frame on the last byte of the frame. The block
// sustains one pixel per clock but for output stalls; each accepted pixel waits in the
// diffusion stage, then its byte is loaded into the output register until it is taken.
// That rate is set by the line-error memory: its entry for the column is
// read when the pixel is accepted, and the following stage adds it to the error pushed from
// the left neighbour, quantizes against the threshold and writes one finished next-row error
// back in the same cycle, so the right-error feedback closes within one stage. A registered
// output with its own valid lets the next pixel enter while a byte waits to be taken; the
// input stalls only when a byte is due and the output register is still held. After reset no
// clearing pass is needed: the first row reads its incoming errors as zero, and every entry
// but the last column's is written in that row. The threshold and image height registers
// lie at byte addresses 0 and 4 and should be written only while no pixel is in flight.
module error_diffusion_dither_1bit import efd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PIX_W-1:0]    pixel_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          packed_byte_o,
  output logic                end_of_frame_o
);

  logic [THR_W-1:0]    threshold;
  logic [HEIGHT_W-1:0] height;

  efd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .threshold_o (threshold),
    .height_o    (height)
  );

  // Position counters advance as each item is accepted.
  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    row_q;
  logic [HEIGHT_W-1:0] height_eff;
  logic                acc_in, last_col, last_row;

  // A height of zero behaves as one, and heights above the maximum are capped.
  always_comb begin
    if (height == '0) begin
      height_eff = HEIGHT_W'(1);
    end else if (height > MAX_HEIGHT) begin
      height_eff = MAX_HEIGHT;
    end else begin
      height_eff = height;
    end
  end

  assign last_col = (col_q == COL_W'(LINE_WIDTH - 1));
  assign last_row = ({1'b0, row_q} + HEIGHT_W'(1)) >= height_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc_in) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // Diffusion stage: holds the accepted pixel while its memory read completes.
  logic             s1_valid_q, s1_fire, s1_adv;
  efd_ctl_t         s1_ctl_q;
  logic [PIX_W-1:0] s1_pixel_q;
  logic             emit, eof;
  logic [7:0]       byte_val;
  logic             ram_we;
  logic [COL_W-1:0] ram_waddr;
  err_t             ram_wdata;
  logic [ERROR_BITS-1:0] ram_rdata;
  logic             out_valid_q, out_eof_q;
  logic [7:0]       out_byte_q;

  assign s1_adv     = !emit || !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign acc_in     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= acc_in || (s1_valid_q && !s1_fire);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_in) begin
      s1_ctl_q   <= '{col: col_q, last_col: last_col, last_row: last_row};
      s1_pixel_q <= pixel_i;
    end
  end

  // Read data stays put while the stage is stalled, since reads are issued only on accept.
  efd_ram #(
    .WIDTH (ERROR_BITS),
    .DEPTH (LINE_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (acc_in),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  efd_diffuse u_diffuse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (s1_fire),
    .ctl_i       (s1_ctl_q),
    .pixel_i     (s1_pixel_q),
    .threshold_i (threshold),
    .rdata_i     (ram_rdata),
    .we_o        (ram_we),
    .waddr_o     (ram_waddr),
    .wdata_o     (ram_wdata),
    .emit_o      (emit),
    .byte_o      (byte_val),
    .eof_o       (eof)
  );

  // Output register: a finished byte waits here until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && emit) begin
      out_byte_q <= byte_val;
      out_eof_q  <= eof;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign packed_byte_o  = out_byte_q;
  assign end_of_frame_o = out_eof_q;

endmodule

[rtl/efd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module efd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(DEPTH)-1:0]         waddr_i,
  input  logic [WIDTH-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(DEPTH)-1:0]         raddr_i,
  output logic [WIDTH-1:0]                 rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/efd_cfg.sv]
// Configuration registers behind the APB-style port.
module efd_cfg import efd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  output logic [THR_W-1:0]    threshold_o,
  output logic [HEIGHT_W-1:0] height_o
);

  logic [THR_W-1:0]    threshold_q;
  logic [HEIGHT_W-1:0] height_q;
  logic                wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
      height_q    <= HEIGHT_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        REG_THRESHOLD: threshold_q <= pwdata[THR_W-1:0];
        REG_HEIGHT:    height_q    <= pwdata[HEIGHT_W-1:0];
        default:       threshold_q <= threshold_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_THRESHOLD: prdata = {{(APB_DW-THR_W){1'b0}}, threshold_q};
      REG_HEIGHT:    prdata = {{(APB_DW-HEIGHT_W){1'b0}}, height_q};
      default:       prdata = '0;
    endcase
  end

  assign threshold_o = threshold_q;
  assign height_o    = height_q;

endmodule

[rtl/efd_diffuse.sv]
// Per-pixel quantizer, error spreading and bit packing around the line-error memory.
module efd_diffuse import efd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  efd_ctl_t           ctl_i,
  input  logic [PIX_W-1:0]   pixel_i,
  input  logic [THR_W-1:0]   threshold_i,
  input  err_t               rdata_i,
  output logic               we_o,
  output logic [COL_W-1:0]   waddr_o,
  output err_t               wdata_o,
  output logic               emit_o,
  output logic [7:0]         byte_o,
  output logic               eof_o
);

  err_t right_q, dc0_q, dc1_q, tail_q;
  logic [7:0] shifter_q;
  logic       first_row_q;

  err_t                     err_in, v, e7, e3, e5, e1, down_left, down_mid;
  logic signed [SUM_W-1:0]  sum;
  logic                     lit;
  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] dx, p7, p3, p5;
  logic [7:0]               sh_new;
  logic                     clr_here;

  // The last column lives in a register, so the memory takes at most one write per pixel.
  // Until the first row has passed, memory entries have never been written and read as zero.
  assign err_in = ctl_i.last_col ? tail_q : (first_row_q ? '0 : rdata_i);

  assign sum = $signed({{(SUM_W-PIX_W){1'b0}}, pixel_i}) + SUM_W'(right_q) + SUM_W'(err_in);
  assign v   = sat_err(sum);
  assign lit = v > $signed({{(ERROR_BITS-THR_W){1'b0}}, threshold_i});

  assign diff = DIFF_W'(v) - $signed({{(DIFF_W-PIX_W){1'b0}}, {PIX_W{lit}}});
  assign dx   = PROD_W'(diff);
  assign p7   = (dx <<< 3) - dx;
  assign p3   = (dx <<< 1) + dx;
  assign p5   = (dx <<< 2) + dx;
  assign e7   = div16(p7);
  assign e3   = div16(p3);
  assign e5   = div16(p5);
  assign e1   = div16(dx);

  assign down_left = sat_err(SUM_W'(dc0_q) + SUM_W'(e3));
  assign down_mid  = sat_err(SUM_W'(dc1_q) + SUM_W'(e5));

  // On the last row each entry is cleared as it is used; otherwise column col-1 is completed.
  // In the first row after reset a last-row pixel clears column col-1 instead, so that the
  // entry left behind when that row turns into the last row part way is still written as zero.
  assign clr_here = ctl_i.last_row && !first_row_q;
  assign we_o     = fire_i && (clr_here ? !ctl_i.last_col : (ctl_i.col != '0));
  assign waddr_o  = clr_here ? ctl_i.col : ctl_i.col - COL_W'(1);
  assign wdata_o  = ctl_i.last_row ? '0 : down_left;

  assign sh_new = {shifter_q[6:0], lit};
  assign emit_o = (ctl_i.col[2:0] == 3'd7) || ctl_i.last_col;
  assign byte_o = sh_new << (~ctl_i.col[2:0]);
  assign eof_o  = ctl_i.last_col && ctl_i.last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q     <= '0;
      dc0_q       <= '0;
      dc1_q       <= '0;
      tail_q      <= '0;
      shifter_q   <= '0;
      first_row_q <= 1'b1;
    end else if (fire_i) begin
      right_q   <= ctl_i.last_col ? '0 : e7;
      shifter_q <= emit_o ? '0 : sh_new;
      if (ctl_i.last_col) begin
        first_row_q <= 1'b0;
      end
      if (ctl_i.last_row) begin
        dc0_q <= '0;
        dc1_q <= '0;
        if (ctl_i.last_col) begin
          tail_q <= '0;
        end
      end else if (ctl_i.last_col) begin
        tail_q <= down_mid;
        dc0_q  <= '0;
        dc1_q  <= '0;
      end else begin
        dc0_q <= down_mid;
        dc1_q <= e1;
      end
    end
  end

endmodule
